// ----- hdl/bss_pkg.sv -----
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types for the bounded stack: action codes, port beats and the
// classified command that passes from the front queue to the engine.
// ----------------------------------------------------------------------------
package bss_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned CapWidth  = 5;
   localparam int unsigned CntWidth  = 5;
   localparam int unsigned IdxWidth  = 4;

   typedef enum logic [1:0] {
      ACT_PUSH   = 2'd0,
      ACT_POP    = 2'd1,
      ACT_SEARCH = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef struct packed {
      action_type                   action;
      logic signed [DataWidth-1:0]  push_value;
      logic signed [DataWidth-1:0]  search_key;
   } req_item_type;

   typedef struct packed {
      logic                         ok;
      logic [CntWidth-1:0]          count;
      logic                         full_res;
      logic                         empty_res;
      logic signed [DataWidth-1:0]  top_value;
      logic signed [DataWidth-1:0]  bottom_value;
      logic                         found;
      logic [IdxWidth-1:0]          found_index;
   } rsp_item_type;

   // push carries the value, search carries the key
   typedef struct packed {
      action_type                   act;
      logic signed [DataWidth-1:0]  operand;
   } cmd_type;

endpackage

// ----- hdl/bss_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// bss_cmd_queue
// Front end: takes request beats, keeps only the operand the action needs,
// and buffers up to two commands for the engine.
// ----------------------------------------------------------------------------
module bss_cmd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  bss_pkg::req_item_type req_data,
   output logic                  cmd_valid,
   output bss_pkg::cmd_type      cmd,
   input  logic                  cmd_take
);

   bss_pkg::cmd_type q_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   bss_pkg::cmd_type new_cmd;
   logic             do_wr, do_rd;

   assign req_full  = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   assign do_wr = req_push && !req_full;
   assign do_rd = cmd_take && cmd_valid;

   always_comb begin
      new_cmd.act     = req_data.action;
      new_cmd.operand = (req_data.action == bss_pkg::ACT_SEARCH) ? req_data.search_key
                                                                 : req_data.push_value;
      wr_ptr_in = do_wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ----- hdl/bss_engine.sv -----
// ----------------------------------------------------------------------------
// bss_engine
// Back end: owns the entry memory and the fill count, carries out one
// command at a time and loads the result register.
// ----------------------------------------------------------------------------
module bss_engine #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [bss_pkg::CapWidth-1:0]  capacity,
   input  logic                          cmd_valid,
   input  bss_pkg::cmd_type              cmd,
   output logic                          cmd_take,
   output logic                          rsp_valid,
   output bss_pkg::rsp_item_type         rsp_data,
   input  logic                          rsp_pop
);

   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW   = $clog2(DEPTH + 1);
   localparam int unsigned CMPW = (CW > bss_pkg::CapWidth) ? CW : bss_pkg::CapWidth;
   localparam int unsigned IXW  = (AW > bss_pkg::IdxWidth) ? AW : bss_pkg::IdxWidth;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP_RD,
      ST_SCAN
   } state_type;

   state_type                          state_ff, state_in;
   logic [CW-1:0]                      count_ff, count_in;
   logic signed [bss_pkg::DataWidth-1:0] top_ff, top_in;
   logic signed [bss_pkg::DataWidth-1:0] bottom_ff, bottom_in;
   logic signed [bss_pkg::DataWidth-1:0] key_ff, key_in;
   logic [CW-1:0]                      scan_ff, scan_in;
   logic                               cmp_vld_ff, cmp_vld_in;
   logic [AW-1:0]                      cmp_idx_ff, cmp_idx_in;
   logic                               found_ff, found_in;
   logic [AW-1:0]                      fidx_ff, fidx_in;
   logic                               rsp_vld_ff, rsp_vld_in;
   bss_pkg::rsp_item_type              rsp_ff, rsp_in;

   logic signed [bss_pkg::DataWidth-1:0] mem [DEPTH];
   logic signed [bss_pkg::DataWidth-1:0] rd_data_ff;
   logic [AW-1:0]                      rd_addr, wr_addr;
   logic                               wr_en;
   logic signed [bss_pkg::DataWidth-1:0] wr_data;

   logic [CMPW-1:0]                    cap_ext, eff_cap, cnt_ext, cnt_new_ext;
   logic [CW-1:0]                      cnt_m2;
   logic [IXW-1:0]                     fidx_ext;
   logic                               slot_free, emit, r_ok, r_found;
   logic [AW-1:0]                      r_fidx;

   assign cap_ext   = CMPW'(capacity);
   assign eff_cap   = (cap_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_ext;
   assign cnt_ext   = CMPW'(count_ff);
   assign cnt_m2    = count_ff - CW'(2);
   assign slot_free = !rsp_vld_ff || rsp_pop;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      top_in     = top_ff;
      bottom_in  = bottom_ff;
      key_in     = key_ff;
      scan_in    = scan_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      found_in   = found_ff;
      fidx_in    = fidx_ff;
      cmd_take   = 1'b0;
      emit       = 1'b0;
      r_ok       = 1'b1;
      r_found    = 1'b0;
      r_fidx     = '0;
      wr_en      = 1'b0;
      wr_addr    = count_ff[AW-1:0];
      wr_data    = cmd.operand;
      rd_addr    = cnt_m2[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && slot_free) begin
               cmd_take = 1'b1;
               unique case (cmd.act)
                  bss_pkg::ACT_PUSH: begin
                     emit = 1'b1;
                     r_ok = 1'b0;
                     if (cnt_ext < eff_cap) begin
                        r_ok     = 1'b1;
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                        top_in   = cmd.operand;
                        if (count_ff == '0) begin
                           bottom_in = cmd.operand;
                        end
                     end
                  end
                  bss_pkg::ACT_POP: begin
                     if (count_ff == '0) begin
                        r_ok = 1'b0;
                        emit = 1'b1;
                     end else begin
                        count_in = count_ff - CW'(1);
                        if (count_ff == CW'(1)) begin
                           emit = 1'b1;
                        end else begin
                           // new top comes back from the memory next cycle
                           state_in = ST_POP_RD;
                        end
                     end
                  end
                  bss_pkg::ACT_SEARCH: begin
                     key_in   = cmd.operand;
                     scan_in  = '0;
                     found_in = 1'b0;
                     fidx_in  = '0;
                     state_in = ST_SCAN;
                  end
                  bss_pkg::ACT_CLEAR: begin
                     count_in = '0;
                     emit     = 1'b1;
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end
         ST_POP_RD: begin
            top_in   = rd_data_ff;
            emit     = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            // read one entry per cycle, compare it in the cycle after
            rd_addr = scan_ff[AW-1:0];
            if (scan_ff < count_ff) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_ff[AW-1:0];
               scan_in    = scan_ff + CW'(1);
            end
            if (cmp_vld_ff && (rd_data_ff == key_ff)) begin
               found_in = 1'b1;
               fidx_in  = cmp_idx_ff;
            end
            if ((scan_ff >= count_ff) && !cmp_vld_ff) begin
               r_found  = found_ff;
               r_fidx   = fidx_ff;
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cnt_new_ext           = CMPW'(count_in);
      fidx_ext              = IXW'(r_fidx);
      rsp_in                = rsp_ff;
      rsp_vld_in            = rsp_vld_ff && !rsp_pop;
      if (emit) begin
         rsp_vld_in          = 1'b1;
         rsp_in.ok           = r_ok;
         rsp_in.count        = cnt_new_ext[bss_pkg::CntWidth-1:0];
         rsp_in.full_res     = (cnt_new_ext >= eff_cap);
         rsp_in.empty_res    = (count_in == '0);
         rsp_in.top_value    = (count_in == '0) ? -32'sd1 : top_in;
         rsp_in.bottom_value = (count_in == '0) ? -32'sd1 : bottom_in;
         rsp_in.found        = r_found;
         rsp_in.found_index  = fidx_ext[bss_pkg::IdxWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff     <= top_in;
      bottom_ff  <= bottom_in;
      key_ff     <= key_in;
      scan_ff    <= scan_in;
      cmp_idx_ff <= cmp_idx_in;
      found_ff   <= found_in;
      fidx_ff    <= fidx_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// ----- hdl/bounded_stack_with_search_top.sv -----
// ----------------------------------------------------------------------------
// bounded_stack_with_search_top
// Bounded LIFO of signed 32-bit words with push, pop, search and clear.
// ----------------------------------------------------------------------------
// Request side: drive req_data and raise req_push; the beat is taken on an
// edge where req_full is low. A two-entry command queue sits in front of the
// engine, so requests keep flowing while a result waits.
// Result side: while rsp_empty is low, rsp_data holds the oldest result;
// raise rsp_pop to take it. One result per request, in request order.
// The engine takes a command from the queue while it is idle and the result
// register is free or being popped. Push, clear, a refused pop and a pop that
// empties the stack load their result as the engine takes them; other pops
// first read the new top back from the entry memory; search reads one entry per
// cycle through the single memory read port and compares it in the cycle after.
// The engine handles one command at a time, so it takes no new command until
// the result of the last one is loaded.
// If rsp_pop stays low the result register holds, the engine stops after it,
// and req_full rises once the command queue has two commands in it.
// csr_we with csr_wdata writes the capacity; change it only when idle.
// Reset empties the stack and both queues and sets the capacity to 16.
// Entry contents are not cleared and are never read before being pushed.
// ----------------------------------------------------------------------------
module bounded_stack_with_search_top #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  bss_pkg::req_item_type         req_data,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output bss_pkg::rsp_item_type         rsp_data,
   input  logic                          csr_we,
   input  logic [bss_pkg::CapWidth-1:0]  csr_wdata
);

   logic [bss_pkg::CapWidth-1:0] cap_ff, cap_in;
   logic                         cmd_valid, cmd_take, rsp_valid;
   bss_pkg::cmd_type             cmd;

   assign cap_in    = csr_we ? csr_wdata : cap_ff;
   assign rsp_empty = !rsp_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= bss_pkg::CapWidth'(16);
      end else begin
         cap_ff <= cap_in;
      end
   end

   bss_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   bss_engine #(
      .DEPTH (DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .capacity  (cap_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop)
   );

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.empty_res == (rsp_data.count == '0)))
      else $error("empty flag disagrees with count");

   a_empty_values: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.empty_res) |->
         (rsp_data.top_value == -32'sd1 && rsp_data.bottom_value == -32'sd1))
      else $error("empty stack must report -1 top and bottom");

   a_found_nonempty: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.found) |-> !rsp_data.empty_res)
      else $error("match reported on an empty stack");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

endmodule

// ----- test/bounded_stack_with_search_top_tb.sv -----
// ----------------------------------------------------------------------------
// bounded_stack_with_search_top_tb
// Drives push, pop, search and clear requests into the bounded stack and
// checks every status beat against a stack model kept in the bench. A short
// directed table covers empty, full and lowered capacity, then random phases
// with sender gaps and receiver stalls run about 1250 more requests.
// ----------------------------------------------------------------------------
module bounded_stack_with_search_top_tb;

   localparam int unsigned StackDepth = 16;
   localparam int unsigned StallLimit = 5000;
   localparam int unsigned NumPhases  = 8;

   logic                         clock;
   logic                         reset     = 1'b1;
   logic                         req_push  = 1'b0;
   logic                         req_full;
   bss_pkg::req_item_type        req_data  = '0;
   logic                         rsp_empty;
   logic                         rsp_pop   = 1'b0;
   bss_pkg::rsp_item_type        rsp_data;
   logic                         csr_we    = 1'b0;
   logic [bss_pkg::CapWidth-1:0] csr_wdata = '0;

   bounded_stack_with_search_top #(
      .DEPTH (StackDepth)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // stack model
   logic signed [bss_pkg::DataWidth-1:0] model_words [StackDepth];
   int unsigned                          model_count = 0;
   int unsigned                          model_cap   = 16;

   bss_pkg::rsp_item_type stack_status_q [$];
   int unsigned           status_errors = 0;
   int unsigned           status_beats  = 0;
   int unsigned           send_idle_pct = 0;
   int unsigned           rsp_stall_pct = 0;
   int unsigned           stall_cycles  = 0;

   typedef struct {
      bit                           cap_row;    // capacity write instead of a request
      logic [bss_pkg::CapWidth-1:0] cap_val;
      bss_pkg::req_item_type        req;
      bit                           typed_in;   // use the literal status below
      bss_pkg::rsp_item_type        status;
   } dir_row_type;

   dir_row_type dir_rows [$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // --- stack model --------------------------------------------------------

   function automatic bss_pkg::rsp_item_type stack_apply(bss_pkg::req_item_type r);
      bss_pkg::rsp_item_type o;
      int unsigned           lim;
      lim = (model_cap > StackDepth) ? StackDepth : model_cap;
      o   = '0;
      case (r.action)
         bss_pkg::ACT_PUSH: begin
            if (model_count < lim) begin
               model_words[model_count] = r.push_value;
               model_count++;
               o.ok = 1'b1;
            end
         end
         bss_pkg::ACT_POP: begin
            if (model_count > 0) begin
               model_count--;
               o.ok = 1'b1;
            end
         end
         bss_pkg::ACT_SEARCH: begin
            o.ok = 1'b1;
            // match nearest the top (highest index) wins
            for (int i = 0; i < model_count; i++) begin
               if (model_words[i] == r.search_key) begin
                  o.found       = 1'b1;
                  o.found_index = bss_pkg::IdxWidth'(i);
               end
            end
         end
         default: begin
            model_count = 0;
            o.ok        = 1'b1;
         end
      endcase
      o.count     = bss_pkg::CntWidth'(model_count);
      o.full_res  = (model_count >= lim);
      o.empty_res = (model_count == 0);
      if (model_count > 0) begin
         o.top_value    = model_words[model_count-1];
         o.bottom_value = model_words[0];
      end else begin
         o.top_value    = -1;
         o.bottom_value = -1;
      end
      return o;
   endfunction

   // --- stimulus helpers ---------------------------------------------------

   function automatic bss_pkg::rsp_item_type lit_status(bit ok, int unsigned cnt, bit full,
                                                        bit empty, logic [31:0] top,
                                                        logic [31:0] bottom);
      bss_pkg::rsp_item_type o;
      o              = '0;
      o.ok           = ok;
      o.count        = bss_pkg::CntWidth'(cnt);
      o.full_res     = full;
      o.empty_res    = empty;
      o.top_value    = top;
      o.bottom_value = bottom;
      return o;
   endfunction

   function automatic void add_cap_row(logic [bss_pkg::CapWidth-1:0] v);
      dir_row_type row;
      row         = '{default: '0};
      row.cap_row = 1'b1;
      row.cap_val = v;
      dir_rows.push_back(row);
   endfunction

   function automatic void add_req_row(bss_pkg::action_type a, logic [31:0] pv,
                                       logic [31:0] key, bit typed_in,
                                       bss_pkg::rsp_item_type st);
      dir_row_type row;
      row                = '{default: '0};
      row.req.action     = a;
      row.req.push_value = pv;
      row.req.search_key = key;
      row.typed_in       = typed_in;
      row.status         = st;
      dir_rows.push_back(row);
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h0000_0000;
         4, 5:    return 32'($urandom_range(0, 3));
         default: return $urandom();
      endcase
   endfunction

   function automatic bss_pkg::req_item_type random_req(bit filling);
      bss_pkg::req_item_type r;
      int unsigned           roll;
      roll         = $urandom_range(0, 99);
      r.push_value = pick_word();
      r.search_key = pick_word();
      if (filling)
         r.action = (roll < 62) ? bss_pkg::ACT_PUSH : (roll < 77) ? bss_pkg::ACT_POP :
                    (roll < 98) ? bss_pkg::ACT_SEARCH : bss_pkg::ACT_CLEAR;
      else
         r.action = (roll < 55) ? bss_pkg::ACT_POP : (roll < 70) ? bss_pkg::ACT_PUSH :
                    (roll < 98) ? bss_pkg::ACT_SEARCH : bss_pkg::ACT_CLEAR;
      // most searches look for a word that is actually stored
      if (r.action == bss_pkg::ACT_SEARCH && model_count > 0 && $urandom_range(0, 99) < 65)
         r.search_key = model_words[$urandom_range(0, model_count-1)];
      return r;
   endfunction

   task automatic send_req(bss_pkg::req_item_type r, bit typed_in,
                           bss_pkg::rsp_item_type st);
      int unsigned           gap;
      bss_pkg::rsp_item_type want;
      gap = 0;
      while (gap < 30 && $urandom_range(0, 99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= r;
      req_push <= 1'b1;
      do
         @(posedge clock);
      while (req_full);
      want = stack_apply(r);
      stack_status_q.push_back(typed_in ? st : want);
   endtask

   // capacity only changes once the engine has gone quiet
   task automatic write_capacity(logic [bss_pkg::CapWidth-1:0] v);
      req_push <= 1'b0;
      while (stack_status_q.size() != 0)
         @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      model_cap = 32'(v);
   endtask

   // --- checking -----------------------------------------------------------

   task automatic flag_status_error(string what, logic [31:0] got, logic [31:0] want);
      status_errors++;
      if (status_errors <= 60)
         $display("status error at %0t, beat %0d: %s got %h want %h",
                  $time, status_beats, what, got, want);
   endtask

   always @(posedge clock) begin
      bss_pkg::rsp_item_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         status_beats++;
         if (stack_status_q.size() == 0) begin
            flag_status_error("beat with nothing pending", 32'(rsp_data.count), 32'd0);
         end else begin
            want = stack_status_q.pop_front();
            if (rsp_data.ok !== want.ok)
               flag_status_error("ok", 32'(rsp_data.ok), 32'(want.ok));
            if (rsp_data.count !== want.count)
               flag_status_error("count", 32'(rsp_data.count), 32'(want.count));
            if (rsp_data.full_res !== want.full_res)
               flag_status_error("full_res", 32'(rsp_data.full_res), 32'(want.full_res));
            if (rsp_data.empty_res !== want.empty_res)
               flag_status_error("empty_res", 32'(rsp_data.empty_res), 32'(want.empty_res));
            if (rsp_data.top_value !== want.top_value)
               flag_status_error("top_value", rsp_data.top_value, want.top_value);
            if (rsp_data.bottom_value !== want.bottom_value)
               flag_status_error("bottom_value", rsp_data.bottom_value, want.bottom_value);
            if (rsp_data.found !== want.found)
               flag_status_error("found", 32'(rsp_data.found), 32'(want.found));
            if (rsp_data.found_index !== want.found_index)
               flag_status_error("found_index", 32'(rsp_data.found_index),
                                 32'(want.found_index));
         end
      end
   end

   always @(posedge clock)
      rsp_pop <= ($urandom_range(0, 99) >= rsp_stall_pct);

   // watchdog: cycles without any beat on either side
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_we)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
         $display("watchdog: no beat for %0d cycles", StallLimit);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // --- main sequence ------------------------------------------------------

   initial begin
      int unsigned                  n_items;
      bit                           filling;
      logic [bss_pkg::CapWidth-1:0] phase_cap [NumPhases];

      // reset capacity is 16
      add_req_row(bss_pkg::ACT_POP,    32'h0, 32'h0, 1'b1,
                  lit_status(1'b0, 0, 1'b0, 1'b1, '1, '1));
      add_req_row(bss_pkg::ACT_SEARCH, 32'h0, 32'h0, 1'b1,
                  lit_status(1'b1, 0, 1'b0, 1'b1, '1, '1));
      add_req_row(bss_pkg::ACT_PUSH, 32'h7FFF_FFFF, 32'h0, 1'b1,
                  lit_status(1'b1, 1, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      add_req_row(bss_pkg::ACT_PUSH, 32'h8000_0000, 32'h0, 1'b1,
                  lit_status(1'b1, 2, 1'b0, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF));
      add_req_row(bss_pkg::ACT_PUSH,   32'hFFFF_FFFF, 32'h0, 1'b0, '0);
      add_req_row(bss_pkg::ACT_PUSH,   32'h7FFF_FFFF, 32'h0, 1'b0, '0);
      add_req_row(bss_pkg::ACT_SEARCH, 32'h0, 32'h7FFF_FFFF, 1'b0, '0);  // duplicate key
      add_req_row(bss_pkg::ACT_SEARCH, 32'h0, 32'h8000_0000, 1'b0, '0);
      add_req_row(bss_pkg::ACT_SEARCH, 32'h0, 32'h1234_5678, 1'b0, '0);  // no match
      add_req_row(bss_pkg::ACT_POP,    32'h0, 32'h0, 1'b0, '0);
      // capacity lowered below the count
      add_cap_row(5'd2);
      add_req_row(bss_pkg::ACT_PUSH,   32'h0, 32'h0, 1'b0, '0);
      add_req_row(bss_pkg::ACT_POP,    32'h0, 32'h0, 1'b0, '0);
      add_req_row(bss_pkg::ACT_POP,    32'h0, 32'h0, 1'b0, '0);
      add_req_row(bss_pkg::ACT_CLEAR,  32'h0, 32'h0, 1'b1,
                  lit_status(1'b1, 0, 1'b0, 1'b1, '1, '1));
      add_req_row(bss_pkg::ACT_CLEAR,  32'h0, 32'h0, 1'b1,
                  lit_status(1'b1, 0, 1'b0, 1'b1, '1, '1));
      add_cap_row(5'd1);
      add_req_row(bss_pkg::ACT_PUSH, 32'd5, 32'h0, 1'b1,
                  lit_status(1'b1, 1, 1'b1, 1'b0, 32'd5, 32'd5));
      add_req_row(bss_pkg::ACT_PUSH, 32'd6, 32'h0, 1'b1,
                  lit_status(1'b0, 1, 1'b1, 1'b0, 32'd5, 32'd5));
      // zero capacity refuses every push and always reads full
      add_cap_row(5'd0);
      add_req_row(bss_pkg::ACT_PUSH,   32'd7, 32'h0, 1'b0, '0);
      add_req_row(bss_pkg::ACT_POP,    32'h0, 32'h0, 1'b1,
                  lit_status(1'b1, 0, 1'b1, 1'b1, '1, '1));
      add_req_row(bss_pkg::ACT_PUSH,   32'd8, 32'h0, 1'b1,
                  lit_status(1'b0, 0, 1'b1, 1'b1, '1, '1));
      // above depth clamps to depth
      add_cap_row(5'd31);
      add_req_row(bss_pkg::ACT_PUSH,   32'hAAAA_AAAA, 32'h0, 1'b0, '0);
      add_req_row(bss_pkg::ACT_PUSH,   32'h5555_5555, 32'h0, 1'b0, '0);
      add_req_row(bss_pkg::ACT_SEARCH, 32'h0, 32'h5555_5555, 1'b0, '0);
      add_req_row(bss_pkg::ACT_POP,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0);

      phase_cap = '{5'd31, 5'd1, 5'd16, 5'd0, 5'd2, 5'd17, 5'd8, 5'd31};
      phase_cap[5] = bss_pkg::CapWidth'($urandom_range(0, 31));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 35;
      rsp_stall_pct = 35;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].cap_row)
            write_capacity(dir_rows[i].cap_val);
         else
            send_req(dir_rows[i].req, dir_rows[i].typed_in, dir_rows[i].status);
      end

      filling = 1'b1;
      for (int ph = 0; ph < NumPhases; ph++) begin
         write_capacity(phase_cap[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 77; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 77; end
            default: begin send_idle_pct = 35; rsp_stall_pct = 35; end
         endcase
         n_items = 150 + $urandom_range(0, 12);
         repeat (n_items) begin
            if ($urandom_range(0, 15) == 0)
               filling = !filling;
            send_req(random_req(filling), 1'b0, '0);
         end
      end
      req_push <= 1'b0;

      while (stack_status_q.size() != 0)
         @(posedge clock);
      repeat (StackDepth + 8) @(posedge clock);
      if (stack_status_q.size() != 0)
         flag_status_error("status beats missing", 32'd0, 32'(stack_status_q.size()));

      if (status_errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/bss_pkg.sv
hdl/bss_cmd_queue.sv
hdl/bss_engine.sv
hdl/bounded_stack_with_search_top.sv
test/bounded_stack_with_search_top_tb.sv
